// ----- src/atlb_pkg.sv -----
// ----------------------------------------------------------------------------
// atlb_pkg
// Shared types and constants of the fully associative TLB.
// ----------------------------------------------------------------------------
package atlb_pkg;

  localparam int unsigned EntriesDef = 8;
  localparam int unsigned VpnW       = 20;
  localparam int unsigned PpnW       = 22;
  localparam int unsigned AccW       = 6;
  localparam int unsigned LvlW       = 10;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_FILL   = 2'd1,
    ACT_FLUSH  = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef struct packed {
    action_e           action;
    logic [VpnW-1:0]   virt_page;
    logic              super_in;
    logic [PpnW-1:0]   phys_page_in;
    logic              acc_in_a;
    logic              acc_in_d;
    logic              acc_in_r;
    logic              acc_in_w;
    logic              acc_in_x;
    logic              acc_in_u;
  } tlb_req_t;

  typedef struct packed {
    logic              hit;
    logic              miss;
    logic              super_out;
    logic [PpnW-1:0]   phys_page_out;
    logic              acc_out_a;
    logic              acc_out_d;
    logic              acc_out_r;
    logic              acc_out_w;
    logic              acc_out_x;
    logic              acc_out_u;
  } tlb_rsp_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } tlb_cmd_t;

endpackage

// ----- src/atlb_ram.sv -----
// ----------------------------------------------------------------------------
// atlb_ram
// Generic single write port RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module atlb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/atlb_ctrl.sv -----
// ----------------------------------------------------------------------------
// atlb_ctrl
// Sequencer: capture, execute, load result register, handshakes.
// ----------------------------------------------------------------------------
module atlb_ctrl
  import atlb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tlb_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LOAD = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        if (slot_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // each transfer in leads to execute then load
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted item not executed");

  a_exec_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> (state_q == S_LOAD))
    else $error("execute not followed by load");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

endmodule

// ----- src/atlb_dp.sv -----
// ----------------------------------------------------------------------------
// atlb_dp
// Tag array, match logic, pseudo-LRU tree, data RAM and result register.
// ----------------------------------------------------------------------------
module atlb_dp
  import atlb_pkg::*;
#(
  parameter int unsigned Entries = EntriesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tlb_cmd_t cmd_i,
  input  tlb_req_t in_data_i,
  output tlb_rsp_t out_data_o
);

  localparam int unsigned IdxW  = $clog2(Entries);
  localparam int unsigned TreeW = (1 << IdxW) - 1;
  localparam int unsigned DataW = AccW + PpnW;
  localparam logic [IdxW:0] EntX = (IdxW+1)'(Entries);

  tlb_req_t             req_q;
  logic [Entries-1:0]   valid_q, valid_d;
  logic [VpnW-1:0]      vpn_q [Entries];
  logic [Entries-1:0]   super_q;
  logic [TreeW-1:0]     tree_q, tree_d;
  logic                 hit_q, miss_q, super_hit_q;
  tlb_rsp_t             out_q;

  logic                 found;
  logic [IdxW-1:0]      hit_idx;
  logic [IdxW-1:0]      victim;
  logic [IdxW-1:0]      vict_raw;
  logic [IdxW:0]        vict_ext;
  logic                 do_fill;
  logic [DataW-1:0]     wdata;
  logic [DataW-1:0]     rdata;

  function automatic logic [IdxW-1:0] tree_walk(input logic [TreeW-1:0] t);
    logic [IdxW:0]   node;
    logic [IdxW-1:0] idx;
    logic            b;
    node = '0;
    idx  = '0;
    for (int l = 0; l < IdxW; l++) begin
      b    = t[node[IdxW-1:0]];
      idx  = IdxW'({idx, b});
      node = {node[IdxW-1:0], 1'b1} + (IdxW+1)'(b);
    end
    return idx;
  endfunction

  function automatic logic [TreeW-1:0] tree_touch(input logic [TreeW-1:0] t,
                                                  input logic [IdxW-1:0] idx);
    logic [IdxW:0]    node;
    logic [TreeW-1:0] r;
    logic             b;
    node = '0;
    r    = t;
    for (int l = 0; l < IdxW; l++) begin
      b                  = idx[IdxW-1-l];
      r[node[IdxW-1:0]]  = !b;
      node               = {node[IdxW-1:0], 1'b1} + (IdxW+1)'(b);
    end
    return r;
  endfunction

  // match, highest index wins
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < Entries; i++) begin
      if (valid_q[i] &&
          vpn_q[i][VpnW-1:LvlW] == req_q.virt_page[VpnW-1:LvlW] &&
          (super_q[i] || vpn_q[i][LvlW-1:0] == req_q.virt_page[LvlW-1:0])) begin
        found   = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
  end

  assign vict_raw = tree_walk(tree_q);
  assign vict_ext = {1'b0, vict_raw};
  assign victim   = (vict_ext >= EntX) ? IdxW'(vict_ext - EntX) : vict_raw;
  assign do_fill  = cmd_i.exec && (req_q.action == ACT_FILL);

  always_comb begin
    tree_d  = tree_q;
    valid_d = valid_q;
    if (cmd_i.exec) begin
      unique case (req_q.action)
        ACT_LOOKUP: begin
          if (found && (&valid_q)) begin
            tree_d = tree_touch(tree_q, hit_idx);
          end
        end
        ACT_FILL: begin
          tree_d          = tree_touch(tree_q, victim);
          valid_d[victim] = 1'b1;
        end
        ACT_FLUSH: begin
          tree_d  = '0;
          valid_d = '0;
        end
        default: begin
          tree_d  = tree_q;
          valid_d = valid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      tree_q  <= '0;
    end else begin
      valid_q <= valid_d;
      tree_q  <= tree_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_data_i;
    end
    if (do_fill) begin
      vpn_q[victim]   <= req_q.virt_page;
      super_q[victim] <= req_q.super_in;
    end
    if (cmd_i.exec) begin
      hit_q       <= (req_q.action == ACT_LOOKUP) && found;
      miss_q      <= (req_q.action == ACT_LOOKUP) && !found;
      super_hit_q <= super_q[hit_idx];
    end
  end

  assign wdata = {req_q.acc_in_u, req_q.acc_in_x, req_q.acc_in_w,
                  req_q.acc_in_r, req_q.acc_in_d, req_q.acc_in_a,
                  req_q.phys_page_in};

  atlb_ram #(
    .Width (DataW),
    .Depth (Entries)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (do_fill),
    .waddr_i (victim),
    .wdata_i (wdata),
    .re_i    (cmd_i.exec),
    .raddr_i (hit_idx),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.hit           <= hit_q;
      out_q.miss          <= miss_q;
      out_q.super_out     <= hit_q && super_hit_q;
      out_q.phys_page_out <= hit_q ? rdata[PpnW-1:0] : '0;
      out_q.acc_out_a     <= hit_q && rdata[PpnW];
      out_q.acc_out_d     <= hit_q && rdata[PpnW+1];
      out_q.acc_out_r     <= hit_q && rdata[PpnW+2];
      out_q.acc_out_w     <= hit_q && rdata[PpnW+3];
      out_q.acc_out_x     <= hit_q && rdata[PpnW+4];
      out_q.acc_out_u     <= hit_q && rdata[PpnW+5];
    end
  end

  assign out_data_o = out_q;

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && req_q.action == ACT_FLUSH) |=> (valid_q == '0 && tree_q == '0))
    else $error("flush left state behind");

  a_hit_miss_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !(hit_q && miss_q))
    else $error("hit and miss together");

  a_fill_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_fill |=> (valid_q != '0))
    else $error("fill left no valid entry");

endmodule

// ----- src/assoc_tlb_tree_plru.sv -----
// ----------------------------------------------------------------------------
// assoc_tlb_tree_plru
// Fully associative Sv32-style TLB with tree pseudo-LRU replacement.
// ----------------------------------------------------------------------------
// Each item (lookup, fill, flush or no-op) passes through capture, execute and
// load in order: it is captured at the input transfer, then all tags are
// matched in parallel, the tree, valid bits and tags are updated and the
// translation data RAM is read, and then the read data moves into the result
// register, from which the result is offered. A new item is taken in the cycle
// after the result register is loaded, so the block does not take a new item
// before it is through with the last one; a result that waits on the output
// holds the next item in the load step.
module assoc_tlb_tree_plru
  import atlb_pkg::*;
#(
  parameter int unsigned Entries = EntriesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tlb_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tlb_rsp_t out_data_o
);

  tlb_cmd_t cmd;

  atlb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  atlb_dp #(
    .Entries (Entries)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// ----- tb/assoc_tlb_tree_plru_tb.sv -----
// ----------------------------------------------------------------------------
// assoc_tlb_tree_plru_tb
// Self-checking bench for the fully associative TLB with tree pseudo-LRU.
// A behavioral copy of the TLB (entries, valid bits and the PLRU tree) runs
// beside the block and predicts every result. Directed cases cover empty
// lookups, no-ops, field extremes, superpages, multiple matches, victim
// choice with a full TLB and flush. Random traffic follows, built from small
// pools of page numbers so that hits, superpage overlaps and replacement are
// frequent. Both handshake sides idle at random, with stretches of none.
// ----------------------------------------------------------------------------
module assoc_tlb_tree_plru_tb;
  import atlb_pkg::*;

  localparam int unsigned NumEntries    = EntriesDef;
  localparam int unsigned TreeLevels    = (NumEntries > 1) ? $clog2(NumEntries) : 1;
  localparam int unsigned TreeNodes     = (1 << TreeLevels) - 1;
  localparam int unsigned WatchdogLimit = 1000;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  tlb_req_t in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  tlb_rsp_t out_data_o;

  // translation state mirrored from accepted transfers
  logic [NumEntries-1:0] tlb_valid = '0;
  logic [VpnW-1:0]       tlb_vpn   [NumEntries];
  logic                  tlb_super [NumEntries];
  logic [PpnW-1:0]       tlb_ppn   [NumEntries];
  logic [AccW-1:0]       tlb_acc   [NumEntries];
  logic [TreeNodes-1:0]  plru_bits = '0;

  tlb_rsp_t pending_translations[$];
  int       err_count   = 0;
  int       result_cnt  = 0;
  int       idle_cycles = 0;
  bit       no_idle     = 1'b0;

  assoc_tlb_tree_plru #(
    .Entries(NumEntries)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int plru_victim();
    int node;
    int idx;
    int b;
    node = 0;
    idx  = 0;
    for (int l = 0; l < TreeLevels; l++) begin
      b    = plru_bits[node];
      idx  = idx * 2 + b;
      node = 2 * node + 1 + b;
    end
    return idx % NumEntries;
  endfunction

  function automatic void plru_touch(int idx);
    int node;
    int b;
    node = 0;
    for (int l = 0; l < TreeLevels; l++) begin
      b               = (idx >> (TreeLevels - 1 - l)) & 1;
      plru_bits[node] = (b == 0);
      node            = 2 * node + 1 + b;
    end
  endfunction

  task automatic translate_access(input tlb_req_t req, output tlb_rsp_t rsp);
    bit all_valid;
    bit found;
    int hit_idx;
    int victim;
    rsp       = '0;
    all_valid = 1'b1;
    found     = 1'b0;
    hit_idx   = 0;
    case (req.action)
      ACT_LOOKUP: begin
        for (int i = 0; i < NumEntries; i++) begin
          if (!tlb_valid[i]) begin
            all_valid = 1'b0;
          end else if (tlb_vpn[i][VpnW-1:LvlW] == req.virt_page[VpnW-1:LvlW] &&
                       (tlb_super[i] || tlb_vpn[i][LvlW-1:0] == req.virt_page[LvlW-1:0])) begin
            found   = 1'b1;
            hit_idx = i;
          end
        end
        if (found) begin
          rsp.hit           = 1'b1;
          rsp.super_out     = tlb_super[hit_idx];
          rsp.phys_page_out = tlb_ppn[hit_idx];
          {rsp.acc_out_u, rsp.acc_out_x, rsp.acc_out_w,
           rsp.acc_out_r, rsp.acc_out_d, rsp.acc_out_a} = tlb_acc[hit_idx];
          if (all_valid) plru_touch(hit_idx);
        end else begin
          rsp.miss = 1'b1;
        end
      end
      ACT_FILL: begin
        victim            = plru_victim();
        tlb_valid[victim] = 1'b1;
        tlb_vpn[victim]   = req.virt_page;
        tlb_super[victim] = req.super_in;
        tlb_ppn[victim]   = req.phys_page_in;
        tlb_acc[victim]   = {req.acc_in_u, req.acc_in_x, req.acc_in_w,
                             req.acc_in_r, req.acc_in_d, req.acc_in_a};
        plru_touch(victim);
      end
      ACT_FLUSH: begin
        tlb_valid = '0;
        plru_bits = '0;
      end
      default: ;
    endcase
  endtask

  function automatic tlb_req_t make_req(action_e act, logic [VpnW-1:0] vpn, logic sup,
                                        logic [PpnW-1:0] ppn, logic [AccW-1:0] acc);
    tlb_req_t req;
    req.action       = act;
    req.virt_page    = vpn;
    req.super_in     = sup;
    req.phys_page_in = ppn;
    req.acc_in_a     = acc[0];
    req.acc_in_d     = acc[1];
    req.acc_in_r     = acc[2];
    req.acc_in_w     = acc[3];
    req.acc_in_x     = acc[4];
    req.acc_in_u     = acc[5];
    return req;
  endfunction

  task automatic report_error(input string msg);
    $display("%s", msg);
    err_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("result %0d field %s: got %h expected %h",
                             result_cnt, name, got, want));
  endtask

  task automatic check_translation(input tlb_rsp_t got);
    tlb_rsp_t want;
    if (pending_translations.size() == 0) begin
      report_error($sformatf("result %0d arrived with nothing expected: %h",
                             result_cnt, got));
    end else begin
      want = pending_translations.pop_front();
      compare_field("hit", got.hit, want.hit);
      compare_field("miss", got.miss, want.miss);
      compare_field("super_out", got.super_out, want.super_out);
      compare_field("phys_page_out", got.phys_page_out, want.phys_page_out);
      compare_field("acc_out_a", got.acc_out_a, want.acc_out_a);
      compare_field("acc_out_d", got.acc_out_d, want.acc_out_d);
      compare_field("acc_out_r", got.acc_out_r, want.acc_out_r);
      compare_field("acc_out_w", got.acc_out_w, want.acc_out_w);
      compare_field("acc_out_x", got.acc_out_x, want.acc_out_x);
      compare_field("acc_out_u", got.acc_out_u, want.acc_out_u);
    end
    result_cnt++;
  endtask

  task automatic send_req(input tlb_req_t req);
    int       gap;
    tlb_rsp_t rsp;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  = req;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    translate_access(req, rsp);
    pending_translations.push_back(rsp);
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    idle_input();
    while (pending_translations.size() != 0) @(posedge clk_i);
  endtask

  // result side
  initial begin : result_sink
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 15);
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      check_translation(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_ready_i && out_valid_o === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WatchdogLimit) begin
      $display("assoc_tlb_tree_plru_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_empty_and_nop();
    send_req(make_req(ACT_LOOKUP, '0, 1'b0, '0, '0));
    send_req(make_req(ACT_LOOKUP, '1, 1'b1, '1, '1));
    send_req(make_req(ACT_NOP, '1, 1'b1, '1, '1));
  endtask

  task automatic test_fill_extremes();
    send_req(make_req(ACT_FILL, '1, 1'b0, '1, '1));
    send_req(make_req(ACT_FILL, '0, 1'b0, '0, '0));
    send_req(make_req(ACT_LOOKUP, '1, 1'b0, '0, '0));
    send_req(make_req(ACT_LOOKUP, '0, 1'b1, '1, '1));
  endtask

  task automatic test_superpage();
    send_req(make_req(ACT_FILL, 20'h556aa, 1'b1, 22'h2aaaaa, 6'b101010));
    send_req(make_req(ACT_LOOKUP, 20'h55555, 1'b0, '0, '0));
    send_req(make_req(ACT_LOOKUP, 20'h5a6aa, 1'b0, '0, '0));
  endtask

  task automatic test_multi_match();
    send_req(make_req(ACT_FILL, 20'h12345, 1'b0, 22'h155555, 6'b010101));
    send_req(make_req(ACT_FILL, 20'h12345, 1'b0, 22'h0f0f0f, 6'b110011));
    send_req(make_req(ACT_LOOKUP, 20'h12345, 1'b0, '0, '0));
  endtask

  task automatic test_replacement();
    repeat (3)
      send_req(make_req(ACT_FILL, VpnW'($urandom), 1'($urandom), PpnW'($urandom),
                        AccW'($urandom)));
    send_req(make_req(ACT_LOOKUP, '1, 1'b0, '0, '0));
    send_req(make_req(ACT_LOOKUP, 20'h12345, 1'b0, '0, '0));
    send_req(make_req(ACT_FILL, 20'habcde, 1'b0, 22'h3c3c3c, 6'b111000));
  endtask

  task automatic test_flush();
    send_req(make_req(ACT_FLUSH, '1, 1'b1, '1, '1));
    send_req(make_req(ACT_LOOKUP, 20'h12345, 1'b0, '0, '0));
  endtask

  task automatic test_random_traffic(input int phases, input int per_phase);
    logic [LvlW-1:0] upper_set [4];
    logic [VpnW-1:0] vpn_pool  [16];
    logic [VpnW-1:0] vpn;
    action_e         act;
    int              pick;
    for (int p = 0; p < phases; p++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      foreach (upper_set[k]) upper_set[k] = LvlW'($urandom);
      foreach (vpn_pool[k]) vpn_pool[k] = {upper_set[$urandom_range(0, 3)], LvlW'($urandom)};
      for (int i = 0; i < per_phase; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) act = ACT_FILL;
        else if (pick < 94) act = ACT_LOOKUP;
        else if (pick < 97) act = ACT_NOP;
        else act = ACT_FLUSH;
        vpn = ($urandom_range(0, 4) == 0) ? VpnW'($urandom) : vpn_pool[$urandom_range(0, 15)];
        // other page in the same superpage region
        if (act == ACT_LOOKUP && $urandom_range(0, 3) == 0) vpn[LvlW-1:0] = LvlW'($urandom);
        send_req(make_req(act, vpn, ($urandom_range(0, 3) == 0), PpnW'($urandom),
                          AccW'($urandom)));
      end
      // hold off new requests until every result is back
      wait_drained();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_and_nop();
    test_fill_extremes();
    test_superpage();
    test_multi_match();
    test_replacement();
    test_flush();
    test_random_traffic(10, 153);
    wait_drained();
    repeat (32) @(posedge clk_i);
    if (err_count == 0) begin
      $display("assoc_tlb_tree_plru_tb passed");
    end else begin
      $display("assoc_tlb_tree_plru_tb failed");
    end
    $finish;
  end

endmodule
